>>> design/rfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_pkg
// Types and fixed-point widths shared by the refraction direction pipeline.
// ----------------------------------------------------------------------------
package rfd_pkg;

   // field widths
   localparam int COMP_W = 16;                   // vector component, signed Q1.14
   localparam int IDX_W  = 16;                   // refractive index, unsigned Q2.14
   localparam int PROD_W = 2 * COMP_W;           // component product, Q2.28
   localparam int DOT_W  = PROD_W + 1;           // sum of three products
   localparam int FRAC   = 28;                   // fraction bits of Q.28 values
   localparam int HALF   = 14;                   // fraction bits of Q.14 values
   localparam int Q28_W  = FRAC + 1;             // values in [0, 1] at Q.28
   localparam int C14_W  = HALF + 1;             // values in [0, 1] at Q.14

   // reciprocal divider and square root
   localparam int NUM_W  = Q28_W;                // dividend and quotient
   localparam int DEN_W  = IDX_W;                // divisor and remainder
   localparam int SQ_W   = C14_W;                // root bits
   localparam int RAD_W  = 2 * SQ_W;             // radicand, padded to whole pairs
   localparam int REM_W  = SQ_W + 2;             // square root remainder

   // datapath widths
   localparam int ETA_W  = NUM_W;                // eta, unsigned Q.14
   localparam int ETA2_W = 2 * ETA_W;            // eta squared, Q.28
   localparam int ETAC_W = ETA_W + C14_W;        // eta * cos, Q.28
   localparam int EI_W   = ETA_W + 1 + COMP_W;   // eta * incident, signed Q.28
   localparam int HP_W   = ETA2_W - FRAC + Q28_W; // integer part of eta^2 times s
   localparam int LP_W   = FRAC + Q28_W;        // fraction part of eta^2 times s
   localparam int P_W    = HP_W + 1;             // eta^2 (1 - cos^2), Q.28
   localparam int MU_W   = ETAC_W + 2;           // signed normal scale, Q.28
   localparam int MN_W   = MU_W + COMP_W;        // scale times normal, Q.42
   localparam int SUM_W  = MN_W + 1;             // component sum, Q.42

   // constants
   localparam logic [Q28_W-1:0]        ONE28     = 29'h1000_0000;
   localparam logic [Q28_W-1:0]        HALF_Q14  = 29'h0000_2000;
   localparam logic signed [SUM_W-1:0] HALF_Q28  = 63'sh0000_0000_0800_0000;
   localparam logic [COMP_W-1:0]       COMP_MAX  = 16'h7fff;
   localparam logic [COMP_W-1:0]       COMP_MIN  = 16'h8000;

   typedef logic [2:0][COMP_W-1:0] vec_type;

   typedef struct packed {
      logic [COMP_W-1:0] incident_x;
      logic [COMP_W-1:0] incident_y;
      logic [COMP_W-1:0] incident_z;
      logic [COMP_W-1:0] normal_x;
      logic [COMP_W-1:0] normal_y;
      logic [COMP_W-1:0] normal_z;
      logic [IDX_W-1:0]  refr_index;
   } req_type;

   typedef struct packed {
      logic [COMP_W-1:0] refracted_x;
      logic [COMP_W-1:0] refracted_y;
      logic [COMP_W-1:0] refracted_z;
      logic              total_reflection;
   } rsp_type;

   // one stage of the restoring divider
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] quo;
   } div_stage_type;

   // one stage of the digit-by-digit square root
   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [SQ_W-1:0]  root;
   } sqrt_stage_type;

   // geometry carried alongside the divider
   typedef struct packed {
      vec_type          inc;
      vec_type          nrm;
      logic [IDX_W-1:0] idx;
      logic             ent;
      logic [C14_W-1:0] c14;
      logic [Q28_W-1:0] s28;
   } dir_a_type;

   // terms carried alongside the square root
   typedef struct packed {
      vec_type                  nrm;
      logic                     ent;
      logic [ETAC_W-1:0]        etac;
      logic [2:0][EI_W-1:0]     ei;
      logic                     tir;
   } dir_b_type;

endpackage
`default_nettype wire

>>> design/rfd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rfd_div (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [rfd_pkg::NUM_W-1:0]  dividend,
   input  logic [rfd_pkg::DEN_W-1:0]  divisor,
   output logic [rfd_pkg::NUM_W-1:0]  quotient
);
   import rfd_pkg::*;

   div_stage_type link   [NUM_W+1];
   div_stage_type stg_ff [NUM_W];
   div_stage_type stg_in [NUM_W];

   // shift one dividend bit into the remainder and try the subtract
   function automatic div_stage_type div_step(input div_stage_type s, input logic b);
      div_stage_type  o;
      logic [DEN_W:0] trial;
      o     = s;
      trial = {s.rem, b};
      if (trial >= {1'b0, s.den}) begin
         o.rem = DEN_W'(trial - {1'b0, s.den});
         o.quo = {s.quo[NUM_W-2:0], 1'b1};
      end else begin
         o.rem = trial[DEN_W-1:0];
         o.quo = {s.quo[NUM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // chain of stages, most significant bit first
   always_comb begin
      link[0].num = dividend;
      link[0].den = divisor;
      link[0].rem = '0;
      link[0].quo = '0;
      for (int j = 0; j < NUM_W; j++) begin
         link[j+1] = stg_ff[j];
         stg_in[j] = div_step(link[j], link[j].num[NUM_W-1-j]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < NUM_W; j++) begin
            stg_ff[j] <= stg_in[j];
         end
      end
   end

   assign quotient = link[NUM_W].quo;

endmodule
`default_nettype wire

>>> design/rfd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rfd_sqrt (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [rfd_pkg::RAD_W-1:0]  radicand,
   output logic [rfd_pkg::SQ_W-1:0]   root
);
   import rfd_pkg::*;

   sqrt_stage_type link   [SQ_W+1];
   sqrt_stage_type stg_ff [SQ_W];
   sqrt_stage_type stg_in [SQ_W];

   // bring down two radicand bits and try root*4+1
   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s,
                                                input logic [1:0] pair);
      sqrt_stage_type   o;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] sub;
      o     = s;
      trial = {s.rem, pair};
      sub   = (REM_W+2)'({s.root, 2'b01});
      if (trial >= sub) begin
         o.rem  = REM_W'(trial - sub);
         o.root = {s.root[SQ_W-2:0], 1'b1};
      end else begin
         o.rem  = trial[REM_W-1:0];
         o.root = {s.root[SQ_W-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      link[0].rad  = radicand;
      link[0].rem  = '0;
      link[0].root = '0;
      for (int j = 0; j < SQ_W; j++) begin
         link[j+1] = stg_ff[j];
         stg_in[j] = sqrt_step(link[j], link[j].rad[RAD_W-1-2*j -: 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < SQ_W; j++) begin
            stg_ff[j] <= stg_in[j];
         end
      end
   end

   assign root = link[SQ_W].root;

endmodule
`default_nettype wire

>>> design/refraction_direction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refraction_direction
// Refracted ray direction by the vector form of Snell's law, fixed point.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request, in order,
// after it passes 51 pipeline stages and the output register. The depth is
// set by the 29-stage restoring divider that forms 1/index and the 15-stage
// square root of k, each giving one bit per stage. The whole pipeline holds
// while a result waits under rsp_stall, so a new request is taken in every
// cycle in which the output register is empty or being emptied. Total
// internal reflection gives a zero vector with total_reflection set.
module refraction_direction (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rfd_pkg::rsp_type rsp_data
);
   import rfd_pkg::*;

   localparam int PIPE_DEPTH = NUM_W + SQ_W + 7;  // stages ahead of the output
   localparam int A_LEN      = NUM_W - 3;         // cos stage up to divider out
   localparam int B_LEN      = SQ_W + 1;          // k stage up to root out
   localparam int SAT_W      = SUM_W - FRAC - COMP_W + 1;

   // pipeline control
   logic                  advance;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;

   vec_type inc_w;
   vec_type nrm_w;

   // stage 1: component products
   logic signed [PROD_W-1:0] prod1_ff [3];
   logic signed [PROD_W-1:0] prod1_in [3];
   dir_a_type                geo1_ff;
   dir_a_type                geo1_in;

   // stage 2: dot product
   logic signed [DOT_W-1:0]  dot2_ff, dot2_in;
   dir_a_type                geo2_ff;

   // stage 3: cosine magnitude
   logic                     ent3_in;
   logic [DOT_W-1:0]         mag3;
   logic [Q28_W-1:0]         c28_3;
   logic [Q28_W-1:0]         rnd3;
   logic [C14_W-1:0]         c14_3_in;
   dir_a_type                geo3_ff;
   dir_a_type                geo3_in;

   // stage 4 onward: 1 - cos^2, delayed to meet the divider
   logic [Q28_W-1:0]         c14sq4;
   dir_a_type                a_in;
   dir_a_type                a_ff [A_LEN];

   // divider for the entering eta
   logic [IDX_W-1:0]         idx_nz;
   logic [NUM_W-1:0]         div_num;
   logic [NUM_W-1:0]         div_quo;

   // stage 30: eta
   logic [ETA_W-1:0]         eta30_ff, eta30_in;
   dir_a_type                sa30_ff;

   // stage 31: eta^2, eta*cos, eta*incident
   logic [ETA2_W-1:0]        eta2_31_ff, eta2_31_in;
   logic [ETAC_W-1:0]        etac31_ff, etac31_in;
   logic [2:0][EI_W-1:0]     ei31_ff, ei31_in;
   dir_a_type                sa31_ff;

   // stage 32: eta^2 times s, split
   logic [HP_W-1:0]          hp32_ff, hp32_in;
   logic [LP_W-1:0]          lp32_ff, lp32_in;
   dir_b_type                b32_ff, b32_in;

   // stage 33 onward: k, delayed to meet the root
   logic [P_W-1:0]           p28_33;
   logic [Q28_W-1:0]         k28_ff, k28_in;
   dir_b_type                b_in;
   dir_b_type                b_ff [B_LEN];
   logic [SQ_W-1:0]          sq_root;

   // stage 49: signed normal scale
   logic signed [MU_W-1:0]   mu49;
   logic signed [MU_W-1:0]   smu49_ff, smu49_in;
   dir_b_type                b49_ff;

   // stage 50: scale times normal
   logic signed [MN_W-1:0]   m50_ff [3];
   logic signed [MN_W-1:0]   m50_in [3];
   dir_b_type                b50_ff;

   // stage 51: component sums with rounding bias
   logic signed [SUM_W-1:0]  sum51_ff [3];
   logic signed [SUM_W-1:0]  sum51_in [3];
   logic                     tir51_ff;

   // output register
   rsp_type                  rsp_ff, rsp_in;
   logic [2:0][COMP_W-1:0]   out_comp;
   logic [SAT_W-1:0]         sat_hi;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // stage 1
   always_comb begin
      inc_w = {req_data.incident_z, req_data.incident_y, req_data.incident_x};
      nrm_w = {req_data.normal_z, req_data.normal_y, req_data.normal_x};
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = PROD_W'($signed(inc_w[i])) * PROD_W'($signed(nrm_w[i]));
      end
      geo1_in     = '0;
      geo1_in.inc = inc_w;
      geo1_in.nrm = nrm_w;
      geo1_in.idx = req_data.refr_index;
   end

   // entering eta = (1 + r/2) / r, zero index taken as the smallest one
   always_comb begin
      idx_nz  = (req_data.refr_index == '0) ? IDX_W'(1) : req_data.refr_index;
      div_num = ONE28 + NUM_W'(idx_nz[IDX_W-1:1]);
   end

   rfd_div u_div (
      .clock    (clock),
      .advance  (advance),
      .dividend (div_num),
      .divisor  (idx_nz),
      .quotient (div_quo)
   );

   // stage 2
   assign dot2_in = DOT_W'(prod1_ff[0]) + DOT_W'(prod1_ff[1]) + DOT_W'(prod1_ff[2]);

   // stage 3: sign test, clamp to one, round to Q.14
   always_comb begin
      ent3_in     = dot2_ff[DOT_W-1];
      mag3        = ent3_in ? DOT_W'(-dot2_ff) : DOT_W'(dot2_ff);
      c28_3       = (mag3 > DOT_W'(ONE28)) ? ONE28 : mag3[Q28_W-1:0];
      rnd3        = c28_3 + HALF_Q14;
      c14_3_in    = rnd3[Q28_W-1:HALF];
      geo3_in     = geo2_ff;
      geo3_in.ent = ent3_in;
      geo3_in.c14 = c14_3_in;
   end

   // stage 4
   always_comb begin
      c14sq4   = Q28_W'(geo3_ff.c14) * Q28_W'(geo3_ff.c14);
      a_in     = geo3_ff;
      a_in.s28 = ONE28 - c14sq4;
   end

   // stage 30: pick eta by direction
   assign eta30_in = a_ff[A_LEN-1].ent ? div_quo : ETA_W'(a_ff[A_LEN-1].idx);

   // stage 31
   always_comb begin
      eta2_31_in = ETA2_W'(eta30_ff) * ETA2_W'(eta30_ff);
      etac31_in  = ETAC_W'(eta30_ff) * ETAC_W'(sa30_ff.c14);
      for (int i = 0; i < 3; i++) begin
         ei31_in[i] = EI_W'($signed({1'b0, eta30_ff})) * EI_W'($signed(sa30_ff.inc[i]));
      end
   end

   // stage 32: product split so neither multiplier grows past Q.28 by Q.28
   always_comb begin
      hp32_in     = HP_W'(eta2_31_ff[ETA2_W-1:FRAC]) * HP_W'(sa31_ff.s28);
      lp32_in     = LP_W'(eta2_31_ff[FRAC-1:0]) * LP_W'(sa31_ff.s28);
      b32_in      = '0;
      b32_in.nrm  = sa31_ff.nrm;
      b32_in.ent  = sa31_ff.ent;
      b32_in.etac = etac31_ff;
      b32_in.ei   = ei31_ff;
   end

   // stage 33: k and the total reflection test
   always_comb begin
      p28_33     = P_W'(hp32_ff) + P_W'(lp32_ff[LP_W-1:FRAC]);
      b_in       = b32_ff;
      b_in.tir   = p28_33 > P_W'(ONE28);
      k28_in     = ONE28 - p28_33[Q28_W-1:0];
   end

   rfd_sqrt u_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand (RAD_W'(k28_ff)),
      .root     (sq_root)
   );

   // stage 49: mu = eta*cos - sqrt(k), negated for a ray inside
   always_comb begin
      mu49     = $signed(MU_W'(b_ff[B_LEN-1].etac) - MU_W'({sq_root, {HALF{1'b0}}}));
      smu49_in = b_ff[B_LEN-1].ent ? mu49 : -mu49;
   end

   // stage 50
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m50_in[i] = MN_W'(smu49_ff) * MN_W'($signed(b49_ff.nrm[i]));
      end
   end

   // stage 51
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum51_in[i] = SUM_W'($signed({b50_ff.ei[i], {HALF{1'b0}}}))
                     + SUM_W'(m50_ff[i]) + HALF_Q28;
      end
   end

   // output: floor to Q.14 and saturate
   always_comb begin
      sat_hi = '0;
      for (int i = 0; i < 3; i++) begin
         sat_hi = sum51_ff[i][SUM_W-1:FRAC+COMP_W-1];
         if ((&sat_hi) || !(|sat_hi)) begin
            out_comp[i] = sum51_ff[i][FRAC+COMP_W-1:FRAC];
         end else begin
            out_comp[i] = sum51_ff[i][SUM_W-1] ? COMP_MIN : COMP_MAX;
         end
         if (tir51_ff) begin
            out_comp[i] = '0;
         end
      end
      rsp_in.refracted_x      = out_comp[0];
      rsp_in.refracted_y      = out_comp[1];
      rsp_in.refracted_z      = out_comp[2];
      rsp_in.total_reflection = tir51_ff;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff    <= prod1_in;
         geo1_ff     <= geo1_in;
         dot2_ff     <= dot2_in;
         geo2_ff     <= geo1_ff;
         geo3_ff     <= geo3_in;
         a_ff[0]     <= a_in;
         for (int k = 1; k < A_LEN; k++) begin
            a_ff[k] <= a_ff[k-1];
         end
         eta30_ff    <= eta30_in;
         sa30_ff     <= a_ff[A_LEN-1];
         eta2_31_ff  <= eta2_31_in;
         etac31_ff   <= etac31_in;
         ei31_ff     <= ei31_in;
         sa31_ff     <= sa30_ff;
         hp32_ff     <= hp32_in;
         lp32_ff     <= lp32_in;
         b32_ff      <= b32_in;
         k28_ff      <= k28_in;
         b_ff[0]     <= b_in;
         for (int k = 1; k < B_LEN; k++) begin
            b_ff[k] <= b_ff[k-1];
         end
         smu49_ff    <= smu49_in;
         b49_ff      <= b_ff[B_LEN-1];
         m50_ff      <= m50_in;
         b50_ff      <= b49_ff;
         sum51_ff    <= sum51_in;
         tir51_ff    <= b50_ff.tir;
         rsp_ff      <= rsp_in;
      end
   end

   // a reflected result carries the zero vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_reflection |->
         rsp_data.refracted_x == '0 && rsp_data.refracted_y == '0 &&
         rsp_data.refracted_z == '0)
      else $error("reflected result with nonzero direction");

   // a held pipeline keeps its valid bits
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("valid bits moved while the pipeline was held");

   // rounded cosine never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> geo3_ff.c14 <= C14_W'(16384))
      else $error("cosine above one after clamp");

   // k lies in [0, 1] whenever there is no total reflection
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_W+3] && !b_ff[0].tir |-> k28_ff <= ONE28)
      else $error("k out of range without total reflection");

endmodule
`default_nettype wire
